// ----- src/svi_pkg.sv -----
// ----------------------------------------------------------------------------
// svi_pkg
// Shared types and constants for the strided view index pipeline.
// ----------------------------------------------------------------------------
package svi_pkg;

	localparam int DIV_BITS = 4;

	localparam logic [2:0] REG_VIEW_RANK    = 3'd0;
	localparam logic [2:0] REG_BASE_OFFSET  = 3'd1;
	localparam logic [2:0] REG_AXIS_EXTENTS = 3'd2;
	localparam logic [2:0] REG_AXIS_STRIDES = 3'd3;

	typedef struct packed {
		logic empty;
		logic contig;
		logic ovf;
	} svi_flags_t;

endpackage

// ----- src/svi_div_step.sv -----
// ----------------------------------------------------------------------------
// svi_div_step
// One register stage of a restoring divider, DIV_BITS quotient bits per stage.
// ----------------------------------------------------------------------------
module svi_div_step
	import svi_pkg::*;
#(
	parameter int PAD = 32,
	parameter int E   = 16,
	parameter int SW  = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  logic           in_valid,
	input  logic [E-1:0]   in_rem,
	input  logic [PAD-1:0] in_num,
	input  logic [SW-1:0]  in_side,
	input  logic [E-1:0]   ext,
	output logic           out_valid,
	output logic [E-1:0]   out_rem,
	output logic [PAD-1:0] out_num,
	output logic [SW-1:0]  out_side
);

	logic [E-1:0]   rem_c;
	logic [PAD-1:0] num_c;

	always_comb begin
		logic [E:0] t;
		logic       q;
		rem_c = in_rem;
		num_c = in_num;
		for (int i = 0; i < DIV_BITS; i++) begin
			t = {rem_c, num_c[PAD-1]};
			if (t >= {1'b0, ext}) begin
				t = t - {1'b0, ext};
				q = 1'b1;
			end else begin
				q = 1'b0;
			end
			rem_c = t[E-1:0];
			num_c = {num_c[PAD-2:0], q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_rem  <= rem_c;
			out_num  <= num_c;
			out_side <= in_side;
		end
	end

endmodule

// ----- src/svi_axis.sv -----
// ----------------------------------------------------------------------------
// svi_axis
// One axis: pipelined divide by extent, coordinate times stride, accumulate.
// ----------------------------------------------------------------------------
module svi_axis
	import svi_pkg::*;
#(
	parameter int N = 32,
	parameter int E = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         adv,
	input  logic         in_valid,
	input  logic [N-1:0] in_num,
	input  logic [N-1:0] in_sum,
	input  logic [E:0]   in_exp,
	input  svi_flags_t   in_flags,
	input  logic [E-1:0] ext,
	input  logic [E-1:0] stride,
	output logic         out_valid,
	output logic [N-1:0] out_num,
	output logic [N-1:0] out_sum,
	output logic [E:0]   out_exp,
	output svi_flags_t   out_flags
);

	localparam int STEPS = (N + DIV_BITS - 1) / DIV_BITS;
	localparam int PAD   = STEPS * DIV_BITS;
	localparam int SW    = N + E + 1 + 3;
	localparam int AW    = ((N > 2 * E) ? N : 2 * E) + 1;

	logic           v   [0:STEPS];
	logic [E-1:0]   rem [0:STEPS];
	logic [PAD-1:0] num [0:STEPS];
	logic [SW-1:0]  side[0:STEPS];

	assign v[0]    = in_valid;
	assign rem[0]  = '0;
	assign num[0]  = PAD'(in_num);
	assign side[0] = {in_sum, in_exp, in_flags};

	for (genvar s = 0; s < STEPS; s++) begin : g_div
		svi_div_step #(.PAD(PAD), .E(E), .SW(SW)) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.in_valid (v[s]),
			.in_rem   (rem[s]),
			.in_num   (num[s]),
			.in_side  (side[s]),
			.ext      (ext),
			.out_valid(v[s+1]),
			.out_rem  (rem[s+1]),
			.out_num  (num[s+1]),
			.out_side (side[s+1])
		);
	end

	logic [N-1:0] d_sum;
	logic [E:0]   d_exp;
	svi_flags_t   d_flags;
	assign {d_sum, d_exp, d_flags} = side[STEPS];

	logic           valid_s1;
	logic [2*E-1:0] prod_s1;
	logic [N-1:0]   num_s1;
	logic [N-1:0]   sum_s1;
	logic [E:0]     exp_s1;
	svi_flags_t     flags_s1;

	logic [2*E:0] exp_full;
	logic [E:0]   exp_next;
	svi_flags_t   flags_m;

	always_comb begin
		exp_full = d_exp * ext;
		if (exp_full > (2*E+1)'({1'b1, {E{1'b0}}})) begin
			exp_next = {1'b1, {E{1'b0}}};
		end else begin
			exp_next = exp_full[E:0];
		end
		flags_m        = d_flags;
		flags_m.empty  = d_flags.empty | (ext == '0);
		flags_m.contig = d_flags.contig & !((ext > E'(1)) && ({1'b0, stride} != d_exp));
	end

	logic          valid_s2;
	logic [N-1:0]  num_s2;
	logic [N-1:0]  sum_s2;
	logic [E:0]    exp_s2;
	svi_flags_t    flags_s2;
	logic [AW-1:0] wide;

	assign wide = AW'(sum_s1) + AW'(prod_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= v[STEPS];
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1  <= rem[STEPS] * stride;
			num_s1   <= num[STEPS][N-1:0];
			sum_s1   <= d_sum;
			exp_s1   <= exp_next;
			flags_s1 <= flags_m;
			num_s2   <= num_s1;
			sum_s2   <= wide[N-1:0];
			exp_s2   <= exp_s1;
			flags_s2 <= '{empty: flags_s1.empty, contig: flags_s1.contig,
				ovf: flags_s1.ovf | (|wide[AW-1:N])};
		end
	end

	assign out_valid = valid_s2;
	assign out_num   = num_s2;
	assign out_sum   = sum_s2;
	assign out_exp   = exp_s2;
	assign out_flags = flags_s2;

endmodule

// ----- src/strided_view_index_core.sv -----
// ----------------------------------------------------------------------------
// strided_view_index_core
// Each of the MAX_RANK axes is a chain of divider stages (four quotient bits
// per stage), followed by a product register and an accumulate register.
// Throughput: one item per cycle; a stall at the output holds every stage.
// Reset clears all stage valids and loads the register defaults.
// ----------------------------------------------------------------------------
module strided_view_index_core
	import svi_pkg::*;
#(
	parameter int MAX_RANK    = 4,
	parameter int EXTENT_BITS = 16,
	parameter int INDEX_BITS  = 32,
	localparam int FW  = MAX_RANK * EXTENT_BITS,
	localparam int CFG_W = (FW > INDEX_BITS) ? FW : INDEX_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [INDEX_BITS-1:0] element_number,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [INDEX_BITS-1:0] storage_elem_idx,
	output logic                  index_overflow,
	output logic                  view_contiguous,
	output logic                  empty_view
);

	localparam int N = INDEX_BITS;
	localparam int E = EXTENT_BITS;

	logic [2:0]   view_rank_q;
	logic [N-1:0] base_offset_q;
	logic [FW-1:0] axis_extents_q;
	logic [FW-1:0] axis_strides_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_rank_q    <= '0;
			base_offset_q  <= '0;
			axis_extents_q <= {MAX_RANK{{{(E-1){1'b0}}, 1'b1}}};
			axis_strides_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_VIEW_RANK:    view_rank_q    <= cfg_data[2:0];
				REG_BASE_OFFSET:  base_offset_q  <= cfg_data[N-1:0];
				REG_AXIS_EXTENTS: axis_extents_q <= cfg_data[FW-1:0];
				REG_AXIS_STRIDES: axis_strides_q <= cfg_data[FW-1:0];
				default: ;
			endcase
		end
	end

	logic adv;
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	logic         v    [0:MAX_RANK];
	logic [N-1:0] num  [0:MAX_RANK];
	logic [N-1:0] sum  [0:MAX_RANK];
	logic [E:0]   expv [0:MAX_RANK];
	svi_flags_t   flg  [0:MAX_RANK];

	assign v[0]    = in_valid;
	assign num[0]  = element_number;
	assign sum[0]  = base_offset_q;
	assign expv[0] = (E+1)'(1);
	assign flg[0]  = '{empty: 1'b0, contig: 1'b1, ovf: 1'b0};

	for (genvar k = 0; k < MAX_RANK; k++) begin : g_axis
		localparam int AX = MAX_RANK - 1 - k;
		logic         used;
		logic [E-1:0] ext;
		logic [E-1:0] stride;
		assign used   = view_rank_q > 3'(AX);
		assign ext    = used ? axis_extents_q[(MAX_RANK-1-AX)*E +: E] : E'(1);
		assign stride = used ? axis_strides_q[(MAX_RANK-1-AX)*E +: E] : '0;

		svi_axis #(.N(N), .E(E)) u_axis (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.in_valid (v[k]),
			.in_num   (num[k]),
			.in_sum   (sum[k]),
			.in_exp   (expv[k]),
			.in_flags (flg[k]),
			.ext      (ext),
			.stride   (stride),
			.out_valid(v[k+1]),
			.out_num  (num[k+1]),
			.out_sum  (sum[k+1]),
			.out_exp  (expv[k+1]),
			.out_flags(flg[k+1])
		);
	end

	svi_flags_t fl;
	assign fl = flg[MAX_RANK];

	assign out_valid        = v[MAX_RANK];
	assign storage_elem_idx = fl.empty ? base_offset_q : sum[MAX_RANK];
	assign index_overflow   = !fl.empty && fl.ovf;
	assign view_contiguous  = fl.empty || fl.contig;
	assign empty_view       = fl.empty;

`ifndef NO_ASSERTIONS
	a_stall_back: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> in_stall)
		else $error("input not held while output stalled");
	a_rank_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && view_rank_q == 3'd0) |->
		(storage_elem_idx == base_offset_q && !index_overflow && view_contiguous))
		else $error("rank zero item not at base offset");
	a_zero_stride: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && axis_strides_q == '0) |->
		(storage_elem_idx == base_offset_q && !index_overflow))
		else $error("zero strides moved the index");
`endif

endmodule

// ----- tb/sv/tb_strided_view_index_core.sv -----
// ----------------------------------------------------------------------------
// tb_strided_view_index_core
// Self-checking bench for the strided view address generator: a queue-fed
// driver, a monitor that compares every result field against a predictor,
// register phases between idle points, and random sender/receiver pacing.
// ----------------------------------------------------------------------------
module tb_strided_view_index_core;
	import svi_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_RANK    = 4;
	localparam int CFG_W       = 64;
	localparam int LATENCY     = 40;
	localparam int IDLE_LIMIT  = 20000;
	localparam logic [2:0] REG_UNMAPPED = 3'd5;

	typedef struct packed {
		logic [31:0] idx;
		logic        ovf;
		logic        contig;
		logic        empty;
	} view_result_t;

	logic              clk = 0;
	logic              arst_n = 0;
	logic              cfg_we = 0;
	logic [2:0]        cfg_index = '0;
	logic [CFG_W-1:0]  cfg_data = '0;
	logic              in_valid = 0;
	logic              in_stall;
	logic [31:0]       element_number = '0;
	logic              out_valid;
	logic              out_stall = 0;
	logic [31:0]       storage_elem_idx;
	logic              index_overflow;
	logic              view_contiguous;
	logic              empty_view;

	strided_view_index_core i_dut (.*);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	// shadow registers of the view
	logic [2:0]  sh_rank = 0;
	logic [31:0] sh_offset = 0;
	logic [63:0] sh_extents = 64'h0001000100010001;
	logic [63:0] sh_strides = 0;

	logic [31:0]  pending_numbers[$];
	view_result_t expected_results[$];
	int           mismatches = 0;
	int           idle_cycles = 0;
	bit           timed_out = 0;
	bit           in_taken = 0;

	function automatic view_result_t map_element(logic [31:0] num);
		view_result_t r;
		int rank;
		logic [63:0] sum, next, ext, str, coord, want, n;
		r = '0;
		rank = (sh_rank > MAX_RANK) ? MAX_RANK : sh_rank;
		r.contig = 1;
		for (int i = 0; i < rank; i++)
			if (sh_extents[(MAX_RANK-1-i)*16 +: 16] == 0) r.empty = 1;
		sum = sh_offset;
		n = num;
		want = 1;
		if (!r.empty) begin
			for (int i = rank - 1; i >= 0; i--) begin
				ext = sh_extents[(MAX_RANK-1-i)*16 +: 16];
				str = sh_strides[(MAX_RANK-1-i)*16 +: 16];
				coord = n % ext;
				n = n / ext;
				next = sum + coord * str;
				if (next > 64'hFFFF_FFFF) r.ovf = 1;
				sum = next;
				if (ext > 1 && str != want) r.contig = 0;
				want = want * ext;
				if (want > 64'h10000) want = 64'h10000;
			end
		end
		r.idx = r.empty ? sh_offset : sum[31:0];
		return r;
	endfunction

	// driver: hold until accepted, then advance in bursts and gaps
	int burst_left = 0, gap_left = 0;
	always @(negedge clk) begin
		if (!in_valid || in_taken) begin
			if (pending_numbers.size() != 0 && gap_left == 0) begin
				in_valid <= 1;
				element_number <= pending_numbers[0];
			end else begin
				in_valid <= 0;
				element_number <= $urandom;
			end
		end
	end

	// accept side: prediction and burst pacing at the rising edge
	always @(posedge clk) begin
		in_taken = arst_n && in_valid && !in_stall;
		if (in_taken) begin
			expected_results.push_back(map_element(element_number));
			void'(pending_numbers.pop_front());
			if (burst_left > 0) burst_left--;
			if (burst_left == 0) begin
				gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				burst_left = $urandom_range(1, 30);
			end
		end else if (gap_left > 0) gap_left--;
	end

	// receiver stall pattern
	int stall_mode = 0;
	always @(negedge clk) begin
		if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: out_stall <= 0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 1) == 0);
			default: out_stall <= ($urandom_range(0, 9) != 0);
		endcase
	end

	// monitor
	always @(posedge clk) begin
		view_result_t got, exp_r;
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (out_valid && !out_stall) begin
				got = {storage_elem_idx, index_overflow, view_contiguous, empty_view};
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected item: %h", got);
				end else begin
					exp_r = expected_results.pop_front();
					if (got !== exp_r) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: idx exp %h got %h ovf %b/%b contig %b/%b empty %b/%b",
								exp_r.idx, got.idx, exp_r.ovf, got.ovf,
								exp_r.contig, got.contig, exp_r.empty, got.empty);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (idle_cycles >= IDLE_LIMIT) timed_out = 1;
	end

	task automatic write_reg(logic [2:0] idx, logic [63:0] val);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 0;
		case (idx)
			REG_VIEW_RANK:    sh_rank = val[2:0];
			REG_BASE_OFFSET:  sh_offset = val[31:0];
			REG_AXIS_EXTENTS: sh_extents = val;
			REG_AXIS_STRIDES: sh_strides = val;
			default: ;
		endcase
	endtask

	task automatic drain();
		while ((pending_numbers.size() != 0 || expected_results.size() != 0) && !timed_out)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	function automatic logic [63:0] pack4(int a, int b, int c, int d);
		return {a[15:0], b[15:0], c[15:0], d[15:0]};
	endfunction

	function automatic logic [63:0] rand_small_ext();
		logic [63:0] v;
		for (int i = 0; i < 4; i++)
			v[i*16 +: 16] = ($urandom_range(0, 19) == 0) ? 16'(0) :
				($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 9));
		return v;
	endfunction

	task automatic load_dense(int rank, logic [63:0] ext, logic [31:0] off);
		logic [63:0] s;
		logic [63:0] p;
		s = 0;
		p = 1;
		for (int i = rank - 1; i >= 0; i--) begin
			s[(3-i)*16 +: 16] = p[15:0];
			p = p * ext[(3-i)*16 +: 16];
		end
		write_reg(REG_VIEW_RANK, rank);
		write_reg(REG_BASE_OFFSET, off);
		write_reg(REG_AXIS_EXTENTS, ext);
		write_reg(REG_AXIS_STRIDES, s);
	endtask

	initial begin
		logic [63:0] e;
		int numel;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// reset defaults, then extremes of the element number
		pending_numbers.push_back(0);
		pending_numbers.push_back(32'hFFFF_FFFF);
		drain();
		load_dense(3, pack4(1, 3, 4, 5), 32'd100);
		for (int k = 0; k < 8; k++) pending_numbers.push_back(k * 7);
		pending_numbers.push_back(60);
		pending_numbers.push_back(32'hFFFF_FFFF);
		drain();
		// rank saturation, full-width strides, overflow
		write_reg(REG_VIEW_RANK, 7);
		write_reg(REG_BASE_OFFSET, 32'hFFFF_FFF0);
		write_reg(REG_AXIS_EXTENTS, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(REG_AXIS_STRIDES, 64'hFFFF_FFFF_FFFF_FFFF);
		pending_numbers.push_back(0);
		pending_numbers.push_back(32'hFFFF_FFFF);
		pending_numbers.push_back(32'h8000_0001);
		drain();
		// empty view and extent wider than 2^16 product
		write_reg(REG_AXIS_EXTENTS, pack4(3, 0, 2, 2));
		pending_numbers.push_back(5);
		drain();
		load_dense(4, pack4(2, 300, 300, 2), 32'd0);
		pending_numbers.push_back(12345);
		pending_numbers.push_back(179999);
		drain();
		write_reg(REG_VIEW_RANK, 0);
		write_reg(REG_UNMAPPED, 64'hDEAD);
		pending_numbers.push_back(99);
		drain();

		// random phases
		for (int ph = 0; ph < 19; ph++) begin
			e = rand_small_ext();
			if ($urandom_range(0, 1)) load_dense($urandom_range(0, 4), e, $urandom);
			else begin
				write_reg(REG_VIEW_RANK, $urandom_range(0, 7));
				write_reg(REG_BASE_OFFSET, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 999));
				write_reg(REG_AXIS_EXTENTS, e);
				write_reg(REG_AXIS_STRIDES, {$urandom, $urandom});
			end
			numel = 1;
			for (int i = 0; i < 4; i++) numel = numel * ((e[i*16 +: 16] % 10) + 1);
			for (int k = 0; k < 100; k++)
				pending_numbers.push_back(($urandom_range(0, 3) == 0) ? $urandom :
					$urandom_range(0, numel * 2));
			drain();
		end

		drain();
		if (timed_out) $display("[strided_view_index_core] ERROR");
		else if (mismatches == 0 && expected_results.size() == 0)
			$display("[strided_view_index_core] OK");
		else $display("[strided_view_index_core] ERROR");
		$finish;
	end
endmodule

// ----- sim.f -----
src/svi_pkg.sv
src/svi_div_step.sv
src/svi_axis.sv
src/strided_view_index_core.sv
tb/sv/tb_strided_view_index_core.sv
